>>> design/length_prefixed_message_fifo_defines.svh
// Assertion macros for the length-prefixed message FIFO.
// Included by the top level; expects clk and rst_n in scope.
`ifndef LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_FIFO_DEFINES_SVH

// condition holds at every edge out of reset
`define LPMF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define LPMF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LPMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lpmf_pkg.sv
// Shared types and constants for the length-prefixed message FIFO.
// No dependencies.
package lpmf_pkg;

    localparam int unsigned DEFAULT_STORE_DEPTH = 1024;
    localparam int unsigned RESET_BUFFER_SIZE   = 1024;
    localparam int unsigned HDR_BYTES           = 2;
    localparam int unsigned BYTE_BITS           = 8;

    localparam int unsigned CFG_W   = 11;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 10;
    localparam int unsigned STS_W   = 2;
    localparam int unsigned REQ_W   = 2;

    // stream widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned M_USED_W  = STS_W + LEN_W + BYTE_W + CNT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BEGIN = 2'd0,
        REQ_PUSH_DATA  = 2'd1,
        REQ_POP_BEGIN  = 2'd2,
        REQ_POP_DATA   = 2'd3
    } req_t;

    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_SEQ   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR2,
        S_POP_HDR,
        S_POP_DATA
    } state_t;

endpackage

>>> design/length_prefixed_message_fifo.sv
// Length-prefixed message FIFO: byte ring of messages with 2-byte headers.
// Depends on lpmf_pkg and length_prefixed_message_fifo_defines.svh.
//
//  channel   | direction | payload
//  ----------+-----------+------------------------------------------------
//  s_*       | in        | tuser: req_type; tdata: length_arg, data_byte
//  m_*       | out       | tdata: status, length_out, data_out, count; tlast
//  cfg_wr_*  | in        | buffer_size, no read-back
//
// push_data is handled in idle; push_begin adds S_HDR2 (second header byte on the
// single write port); pop_begin and pop_data add S_POP_HDR or S_POP_DATA (registered
// read of the store). Rejected and out-of-sequence requests are answered from idle.
// Reset sets pointers, counts, state and ring size only; the store has no clearing pass.
// A request is taken only in idle and while the result register is empty
// or being drained; a stalled result holds the block.
`include "length_prefixed_message_fifo_defines.svh"

module length_prefixed_message_fifo #(
    parameter int unsigned STORE_DEPTH = lpmf_pkg::DEFAULT_STORE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpmf_pkg::S_TDATA_W-1:0]       s_tdata,  // length_arg, data_byte
    input  logic [lpmf_pkg::REQ_W-1:0]           s_tuser,  // req_type
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status, length_out, data_out, message_count, zero pad
    output logic [lpmf_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,  // last_byte
    input  logic                                 cfg_wr_en,
    input  logic [lpmf_pkg::CFG_W-1:0]           cfg_wr_data
);

    localparam int unsigned PTR_W  = $clog2(STORE_DEPTH);
    localparam int unsigned SZ_W   = $clog2(STORE_DEPTH + 1);
    localparam int unsigned CMP_W  = (SZ_W > lpmf_pkg::CFG_W) ? SZ_W : lpmf_pkg::CFG_W;
    localparam int unsigned WIDE_W = ((SZ_W > 17) ? SZ_W : 17) + 1;
    localparam int unsigned LEN_W  = lpmf_pkg::LEN_W;
    localparam int unsigned BYTE_W = lpmf_pkg::BYTE_W;
    localparam int unsigned CNT_W  = lpmf_pkg::CNT_W;

    // effective ring size: buffer_size held to [3, STORE_DEPTH]
    function automatic logic [SZ_W-1:0] ring_clamp(input logic [lpmf_pkg::CFG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (ve < CMP_W'(3))
            return SZ_W'(3);
        else if (ve > CMP_W'(STORE_DEPTH))
            return SZ_W'(STORE_DEPTH);
        else
            return SZ_W'(ve);
    endfunction

    // pointer advance; callers keep p + n below twice the ring size
    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0]  p,
                                                      input logic [WIDE_W-1:0] n,
                                                      input logic [SZ_W-1:0]   ring);
        logic [WIDE_W-1:0] sum;
        sum = WIDE_W'(p) + n;
        if (sum >= WIDE_W'(ring))
            sum = sum - WIDE_W'(ring);
        return PTR_W'(sum);
    endfunction

    // free space grows, saturating at the ring size
    function automatic logic [SZ_W-1:0] give_back(input logic [SZ_W-1:0]   free,
                                                  input logic [WIDE_W-1:0] n,
                                                  input logic [SZ_W-1:0]   ring);
        logic [WIDE_W-1:0] sum;
        sum = WIDE_W'(free) + n;
        return (sum > WIDE_W'(ring)) ? ring : SZ_W'(sum);
    endfunction

    lpmf_pkg::state_t state_reg, state_next;

    logic [SZ_W-1:0]   ring_size_reg, ring_size_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [SZ_W-1:0]   free_reg, free_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LEN_W-1:0]  push_left_reg, push_left_next;
    logic [LEN_W-1:0]  pop_left_reg, pop_left_next;
    logic [LEN_W-1:0]  skip_reg, skip_next;
    logic [LEN_W-1:0]  cap_reg, cap_next;
    logic [BYTE_W-1:0] hdr_lo_reg, hdr_lo_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    lpmf_pkg::status_t     out_status_reg, out_status_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic [BYTE_W-1:0]     out_data_reg, out_data_next;
    logic                  m_tlast_reg, m_tlast_next;
    logic [CNT_W-1:0]      out_count_reg, out_count_next;

    // store and its ports
    logic [BYTE_W-1:0] byte_store_mem [STORE_DEPTH];
    logic              mem_we;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [PTR_W-1:0]  rp_plus1;
    logic [BYTE_W-1:0] rd_hi_reg, rd_lo_reg;

    logic              s_acc;
    logic [LEN_W-1:0]  in_length;
    logic [BYTE_W-1:0] in_byte;
    lpmf_pkg::req_t    in_req;

    logic [WIDE_W-1:0] len_max, len_need;
    logic [LEN_W-1:0]  len_clamp;
    logic [LEN_W-1:0]  hdr_stored, cap_lim, copy_len, skip_len;
    logic [LEN_W-1:0]  pop_left_dec;
    logic [LEN_W-1:0]  push_left_dec;

    assign in_length = s_tdata[LEN_W-1:0];
    assign in_byte   = s_tdata[LEN_W +: BYTE_W];
    assign in_req    = lpmf_pkg::req_t'(s_tuser);

    assign s_tready = (state_reg == lpmf_pkg::S_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_acc    = s_tvalid && s_tready;

    assign len_max   = WIDE_W'(ring_size_reg) - WIDE_W'(lpmf_pkg::HDR_BYTES);
    assign len_clamp = (WIDE_W'(in_length) > len_max) ? LEN_W'(len_max) : in_length;
    assign len_need  = WIDE_W'(len_clamp) + WIDE_W'(lpmf_pkg::HDR_BYTES);

    // header arrives big-endian from the two read ports
    assign hdr_stored = {rd_hi_reg, rd_lo_reg};
    assign cap_lim    = (cap_reg == '0) ? '0 : cap_reg - LEN_W'(1);
    assign copy_len   = (hdr_stored > cap_lim) ? cap_lim : hdr_stored;
    assign skip_len   = hdr_stored - copy_len;

    assign pop_left_dec  = pop_left_reg - LEN_W'(1);
    assign push_left_dec = push_left_reg - LEN_W'(1);
    assign rp_plus1      = ring_advance(rp_reg, WIDE_W'(1), ring_size_reg);

    always_comb
    begin
        state_next      = state_reg;
        ring_size_next  = ring_size_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        push_left_next  = push_left_reg;
        pop_left_next   = pop_left_reg;
        skip_next       = skip_reg;
        cap_next        = cap_reg;
        hdr_lo_next     = hdr_lo_reg;
        mem_we          = 1'b0;
        mem_wdata       = in_byte;
        mem_re          = 1'b0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        out_data_next   = out_data_reg;
        m_tlast_next    = m_tlast_reg;
        out_count_next  = out_count_reg;

        case (state_reg)
            lpmf_pkg::S_IDLE:
            begin
                if (s_acc)
                begin
                    // default result: rejected requests leave the state alone
                    m_tvalid_next   = 1'b1;
                    out_status_next = lpmf_pkg::STS_SEQ;
                    out_len_next    = '0;
                    out_data_next   = '0;
                    m_tlast_next    = 1'b0;
                    out_count_next  = count_reg;
                    case (in_req)
                        lpmf_pkg::REQ_PUSH_BEGIN:
                        begin
                            if (push_left_reg != '0)
                                out_status_next = lpmf_pkg::STS_SEQ;
                            else if (WIDE_W'(free_reg) < len_need)
                                out_status_next = lpmf_pkg::STS_FULL;
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = len_clamp[LEN_W-1 -: BYTE_W];
                                hdr_lo_next     = len_clamp[BYTE_W-1:0];
                                wp_next         = ring_advance(wp_reg, WIDE_W'(1), ring_size_reg);
                                free_next       = SZ_W'(WIDE_W'(free_reg) - len_need);
                                push_left_next  = len_clamp;
                                if (len_clamp == '0)
                                    count_next = count_reg + CNT_W'(1);
                                out_status_next = lpmf_pkg::STS_OK;
                                out_len_next    = len_clamp;
                                out_count_next  = (len_clamp == '0) ? count_reg + CNT_W'(1)
                                                                    : count_reg;
                                state_next      = lpmf_pkg::S_HDR2;
                            end
                        end
                        lpmf_pkg::REQ_PUSH_DATA:
                        begin
                            if (push_left_reg != '0)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = in_byte;
                                wp_next         = ring_advance(wp_reg, WIDE_W'(1), ring_size_reg);
                                push_left_next  = push_left_dec;
                                if (push_left_dec == '0)
                                    count_next = count_reg + CNT_W'(1);
                                out_status_next = lpmf_pkg::STS_OK;
                                out_count_next  = (push_left_dec == '0) ? count_reg + CNT_W'(1)
                                                                        : count_reg;
                            end
                        end
                        lpmf_pkg::REQ_POP_BEGIN:
                        begin
                            if (pop_left_reg != '0)
                                out_status_next = lpmf_pkg::STS_SEQ;
                            else if (count_reg == '0)
                                out_status_next = lpmf_pkg::STS_EMPTY;
                            else
                            begin
                                // result comes after the header read
                                m_tvalid_next = 1'b0;
                                mem_re        = 1'b1;
                                cap_next      = in_length;
                                state_next    = lpmf_pkg::S_POP_HDR;
                            end
                        end
                        lpmf_pkg::REQ_POP_DATA:
                        begin
                            if (pop_left_reg != '0)
                            begin
                                m_tvalid_next = 1'b0;
                                mem_re        = 1'b1;
                                state_next    = lpmf_pkg::S_POP_DATA;
                            end
                        end
                        default:
                        begin
                            out_status_next = lpmf_pkg::STS_SEQ;
                        end
                    endcase
                end
            end
            lpmf_pkg::S_HDR2:
            begin
                mem_we     = 1'b1;
                mem_wdata  = hdr_lo_reg;
                wp_next    = ring_advance(wp_reg, WIDE_W'(1), ring_size_reg);
                state_next = lpmf_pkg::S_IDLE;
            end
            lpmf_pkg::S_POP_HDR:
            begin
                count_next = count_reg - CNT_W'(1);
                if (copy_len == '0)
                begin
                    // nothing to copy: header and whole payload go at once
                    rp_next       = ring_advance(rp_reg,
                                                 WIDE_W'(skip_len) + WIDE_W'(lpmf_pkg::HDR_BYTES),
                                                 ring_size_reg);
                    free_next     = give_back(free_reg,
                                              WIDE_W'(skip_len) + WIDE_W'(lpmf_pkg::HDR_BYTES),
                                              ring_size_reg);
                    pop_left_next = '0;
                    skip_next     = '0;
                end
                else
                begin
                    rp_next       = ring_advance(rp_reg, WIDE_W'(lpmf_pkg::HDR_BYTES),
                                                 ring_size_reg);
                    free_next     = give_back(free_reg, WIDE_W'(lpmf_pkg::HDR_BYTES),
                                              ring_size_reg);
                    pop_left_next = copy_len;
                    skip_next     = skip_len;
                end
                m_tvalid_next   = 1'b1;
                out_status_next = lpmf_pkg::STS_OK;
                out_len_next    = copy_len;
                out_data_next   = '0;
                m_tlast_next    = 1'b0;
                out_count_next  = count_reg - CNT_W'(1);
                state_next      = lpmf_pkg::S_IDLE;
            end
            lpmf_pkg::S_POP_DATA:
            begin
                pop_left_next = pop_left_dec;
                if (pop_left_dec == '0)
                begin
                    // last copied byte: jump the truncated tail too
                    rp_next   = ring_advance(rp_reg, WIDE_W'(skip_reg) + WIDE_W'(1),
                                             ring_size_reg);
                    free_next = give_back(free_reg, WIDE_W'(skip_reg) + WIDE_W'(1),
                                          ring_size_reg);
                    skip_next = '0;
                end
                else
                begin
                    rp_next   = rp_plus1;
                    free_next = give_back(free_reg, WIDE_W'(1), ring_size_reg);
                end
                m_tvalid_next   = 1'b1;
                out_status_next = lpmf_pkg::STS_OK;
                out_len_next    = '0;
                out_data_next   = rd_hi_reg;
                m_tlast_next    = (pop_left_dec == '0);
                out_count_next  = count_reg;
                state_next      = lpmf_pkg::S_IDLE;
            end
            default:
            begin
                state_next = lpmf_pkg::S_IDLE;
            end
        endcase

        // new ring size re-initialises pointers, counts, free space and state, but not the store or the result register
        if (cfg_wr_en)
        begin
            ring_size_next = ring_clamp(cfg_wr_data);
            free_next      = ring_clamp(cfg_wr_data);
            wp_next        = '0;
            rp_next        = '0;
            count_next     = '0;
            push_left_next = '0;
            pop_left_next  = '0;
            skip_next      = '0;
            state_next     = lpmf_pkg::S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpmf_pkg::S_IDLE;
            ring_size_reg <= ring_clamp(lpmf_pkg::CFG_W'(lpmf_pkg::RESET_BUFFER_SIZE));
            free_reg      <= ring_clamp(lpmf_pkg::CFG_W'(lpmf_pkg::RESET_BUFFER_SIZE));
            wp_reg        <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            push_left_reg <= '0;
            pop_left_reg  <= '0;
            skip_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_size_reg <= ring_size_next;
            free_reg      <= free_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            count_reg     <= count_next;
            push_left_reg <= push_left_next;
            pop_left_reg  <= pop_left_next;
            skip_reg      <= skip_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_reg        <= cap_next;
        hdr_lo_reg     <= hdr_lo_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
        out_data_reg   <= out_data_next;
        m_tlast_reg    <= m_tlast_next;
        out_count_reg  <= out_count_next;
    end

    // one write port, two read ports with registered data. A read never
    // meets a write to the same entry: reads only start from idle, and
    // every write has landed by then.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            byte_store_mem[wp_reg] <= mem_wdata;
        if (mem_re)
        begin
            rd_hi_reg <= byte_store_mem[rp_reg];
            rd_lo_reg <= byte_store_mem[rp_plus1];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {(lpmf_pkg::M_TDATA_W - lpmf_pkg::M_USED_W)'(0),
                       out_count_reg, out_data_reg, out_len_reg, out_status_reg};

    `LPMF_ASSERT_ALWAYS(a_free_in_range, free_reg <= ring_size_reg, "free space above ring size")
    `LPMF_ASSERT_ALWAYS(a_ptrs_in_ring, (SZ_W'(wp_reg) < ring_size_reg) && (SZ_W'(rp_reg) < ring_size_reg), "pointer outside ring")
    `LPMF_ASSERT_IMPLY(a_pop_out_empty, (state_reg == lpmf_pkg::S_POP_HDR) || (state_reg == lpmf_pkg::S_POP_DATA), !m_tvalid_reg, "result register busy during pop read")
    `LPMF_ASSERT_NEXT(a_hdr2_done, state_reg == lpmf_pkg::S_HDR2, state_reg == lpmf_pkg::S_IDLE, "second header write did not finish")

endmodule

>>> tb/sv/lpmf_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the length-prefixed message FIFO: watches the request, result and
// configuration ports, keeps a shadow ring and compares every result in order.
// Depends on lpmf_pkg.
module lpmf_checker
    import lpmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // length_arg, data_byte
    input  logic [REQ_W-1:0]     s_tuser,      // req_type
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,      // status, length_out, data_out, message_count
    input  logic                 m_tlast,      // last_byte
    input  logic                 cfg_wr_en,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    output int unsigned          mismatches,
    output int unsigned          outstanding,
    output int unsigned          results_checked,
    output int unsigned          push_open,    // payload bytes still owed by the writer
    output int unsigned          pop_open,     // bytes still to be handed to the reader
    output int unsigned          whole_msgs
);

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] length;
        logic [BYTE_W-1:0] data;
        logic             last_flag;
        logic [CNT_W-1:0] count;
    } fifo_result_t;

    localparam int unsigned PRINT_CAP = 100;

    logic [BYTE_W-1:0] ring_mem [DEFAULT_STORE_DEPTH];
    int unsigned       ring_bytes;
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    int unsigned       free_bytes;
    int unsigned       skip_bytes;
    fifo_result_t      expected_q [$];

    function automatic int unsigned ring_step(input int unsigned p, input int unsigned n);
        return (p + n) % ring_bytes;
    endfunction

    task automatic give_back(input int unsigned n);
        free_bytes = (free_bytes + n > ring_bytes) ? ring_bytes : free_bytes + n;
    endtask

    task automatic clear_ring(input logic [CFG_W-1:0] size_reg);
        ring_bytes = size_reg;
        if (ring_bytes < 3)
            ring_bytes = 3;
        if (ring_bytes > DEFAULT_STORE_DEPTH)
            ring_bytes = DEFAULT_STORE_DEPTH;
        wr_ptr     = 0;
        rd_ptr     = 0;
        free_bytes = ring_bytes;
        whole_msgs = 0;
        push_open  = 0;
        pop_open   = 0;
        skip_bytes = 0;
    endtask

    // jump over whatever the reader had no room for
    task automatic close_pop();
        rd_ptr = ring_step(rd_ptr, skip_bytes);
        give_back(skip_bytes);
        skip_bytes = 0;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_request(input req_t req, input logic [LEN_W-1:0] larg,
                                   input logic [BYTE_W-1:0] db, output fifo_result_t r);
        int unsigned len;
        int unsigned stored;
        int unsigned cap;
        int unsigned take;
        r = '0;
        r.status = STS_OK;
        case (req)
            REQ_PUSH_BEGIN:
            begin
                if (push_open != 0)
                    r.status = STS_SEQ;
                else
                begin
                    len = larg;
                    if (len > ring_bytes - HDR_BYTES)
                        len = ring_bytes - HDR_BYTES;
                    if (free_bytes < len + HDR_BYTES)
                        r.status = STS_FULL;
                    else
                    begin
                        // header is big-endian
                        ring_mem[wr_ptr]               = BYTE_W'(len >> BYTE_BITS);
                        ring_mem[ring_step(wr_ptr, 1)] = BYTE_W'(len);
                        wr_ptr      = ring_step(wr_ptr, HDR_BYTES);
                        free_bytes -= len + HDR_BYTES;
                        push_open   = len;
                        if (len == 0)
                            whole_msgs++;
                        r.length = LEN_W'(len);
                    end
                end
            end
            REQ_PUSH_DATA:
            begin
                if (push_open == 0)
                    r.status = STS_SEQ;
                else
                begin
                    ring_mem[wr_ptr] = db;
                    wr_ptr = ring_step(wr_ptr, 1);
                    push_open--;
                    if (push_open == 0)
                        whole_msgs++;
                end
            end
            REQ_POP_BEGIN:
            begin
                if (pop_open != 0)
                    r.status = STS_SEQ;
                else if (whole_msgs == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    stored = {ring_mem[rd_ptr], ring_mem[ring_step(rd_ptr, 1)]};
                    cap    = (larg == 0) ? 1 : larg;
                    take   = (stored > cap - 1) ? cap - 1 : stored;
                    rd_ptr = ring_step(rd_ptr, HDR_BYTES);
                    give_back(HDR_BYTES);
                    whole_msgs--;
                    pop_open   = take;
                    skip_bytes = stored - take;
                    if (take == 0)
                        close_pop();
                    r.length = LEN_W'(take);
                end
            end
            default:
            begin
                if (pop_open == 0)
                    r.status = STS_SEQ;
                else
                begin
                    r.data = ring_mem[rd_ptr];
                    rd_ptr = ring_step(rd_ptr, 1);
                    give_back(1);
                    pop_open--;
                    if (pop_open == 0)
                    begin
                        r.last_flag = 1'b1;
                        close_pop();
                    end
                end
            end
        endcase
        r.count = CNT_W'(whole_msgs);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        fifo_result_t got;
        if (!rst_n)
        begin
            foreach (ring_mem[i])
                ring_mem[i] = '0;
            clear_ring(CFG_W'(RESET_BUFFER_SIZE));
            expected_q.delete();
            mismatches      = 0;
            results_checked = 0;
            outstanding     = 0;
        end
        else
        begin
            if (cfg_wr_en)
                clear_ring(cfg_wr_data);

            // results leave a register, so none can belong to a request taken at this edge
            if (m_tvalid && m_tready)
            begin
                got.status    = status_t'(m_tdata[1:0]);
                got.length    = m_tdata[17:2];
                got.data      = m_tdata[25:18];
                got.count     = m_tdata[35:26];
                got.last_flag = m_tlast;
                if (expected_q.size() == 0)
                    report_mismatch("result with no request outstanding", got.status, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.length != want.length)
                        report_mismatch("length_out", got.length, want.length);
                    if (got.data != want.data)
                        report_mismatch("data_out", got.data, want.data);
                    if (got.last_flag != want.last_flag)
                        report_mismatch("last_byte", got.last_flag, want.last_flag);
                    if (got.count != want.count)
                        report_mismatch("message_count", got.count, want.count);
                end
                results_checked++;
            end

            if (s_tvalid && s_tready)
            begin
                predict_request(req_t'(s_tuser), s_tdata[15:0], s_tdata[23:16], want);
                expected_q.push_back(want);
            end
            outstanding = expected_q.size();
        end
    end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the message FIFO testbench: clock, reset, request stimulus and result back-pressure.
// Depends on lpmf_pkg, lpmf_checker and the length_prefixed_message_fifo RTL.
module testbench;
    import lpmf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // length_arg, data_byte
    logic [REQ_W-1:0]     s_tuser     = '0;   // req_type
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // status, length_out, data_out, message_count
    logic                 m_tlast;            // last_byte
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned results_checked;
    int unsigned push_open;
    int unsigned pop_open;
    int unsigned whole_msgs;

    int unsigned cycle_count  = 0;
    int unsigned requests_out = 0;
    int unsigned sizes_run    = 0;
    int unsigned ring_bytes   = RESET_BUFFER_SIZE;
    int unsigned idle_pct     = 15;
    int unsigned reader_pct   = 50;
    int unsigned sink_hold    = 0;
    bit          calm         = 1'b0;

    length_prefixed_message_fifo u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    lpmf_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .results_checked(results_checked),
        .push_open      (push_open),
        .pop_open       (pop_open),
        .whole_msgs     (whole_msgs)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result back-pressure: stall bursts of random length
    always @(negedge clk)
    begin
        if (calm || !rst_n)
            m_tready <= 1'b1;
        else if (sink_hold != 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else if ($urandom_range(0, 299) < idle_pct)
        begin
            sink_hold <= $urandom_range(0, 17);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycle_count, outstanding);
        $display("FAIL length_prefixed_message_fifo");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_request(input req_t req, input logic [LEN_W-1:0] larg,
                                input logic [BYTE_W-1:0] db);
        int unsigned gap;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {db, larg};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        requests_out++;
    endtask

    // stop sending, let every result come home and the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_size(input int unsigned size);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= CFG_W'(size);
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        ring_bytes = (size < 3) ? 3 : (size > DEFAULT_STORE_DEPTH) ? DEFAULT_STORE_DEPTH : size;
        sizes_run++;
    endtask

    function automatic logic [LEN_W-1:0] pick_length(input int unsigned room);
        int unsigned r;
        r = $urandom_range(0, 99);
        // long messages are slow on a big ring, so keep them rare there
        if (room > 64 && r > 1)
            return LEN_W'($urandom_range(0, 12));
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'hFFFF;
            1:       return LEN_W'($urandom_range(0, 65535));
            2:       return LEN_W'(room);
            3:       return LEN_W'(room + 1);
            default: return LEN_W'($urandom_range(0, (room < 12) ? room : 12));
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_capacity();
        int unsigned r;
        r = $urandom_range(0, 11);
        case (r)
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return LEN_W'($urandom_range(0, 65535));
            default: return LEN_W'($urandom_range(0, 16));
        endcase
    endfunction

    // mostly well-formed push and pop sequences, interleaved, with some noise
    task automatic random_request();
        bit             writer;
        logic [BYTE_W-1:0] db;
        db = $urandom_range(0, 255);
        if ($urandom_range(0, 99) < 8)
            send_request(req_t'($urandom_range(0, 3)), LEN_W'($urandom_range(0, 65535)), db);
        else
        begin
            writer = ($urandom_range(0, 99) >= reader_pct);
            if (whole_msgs == 0 && pop_open == 0 && $urandom_range(0, 9) != 0)
                writer = 1'b1;
            if (writer && push_open != 0)
                send_request(REQ_PUSH_DATA, LEN_W'($urandom_range(0, 65535)), db);
            else if (writer)
                send_request(REQ_PUSH_BEGIN, pick_length(ring_bytes - HDR_BYTES), db);
            else if (pop_open != 0)
                send_request(REQ_POP_DATA, LEN_W'($urandom_range(0, 65535)), db);
            else
                send_request(REQ_POP_BEGIN, pick_capacity(), db);
        end
    endtask

    task automatic run_phase(input int unsigned size, input int unsigned count,
                             input int unsigned readers, input int unsigned idling,
                             input bit quiet);
        drain();
        write_size(size);
        reader_pct = readers;
        idle_pct   = idling;
        calm       = quiet;
        repeat (count) random_request();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        sizes_run = 1;

        // requests that are out of sequence or find the ring empty
        send_request(REQ_POP_DATA,   16'd0,    8'h00);
        send_request(REQ_PUSH_DATA,  16'd0,    8'hFF);
        send_request(REQ_POP_BEGIN,  16'd5,    8'h00);
        // empty message, read with capacity zero
        send_request(REQ_PUSH_BEGIN, 16'd0,    8'h00);
        send_request(REQ_POP_BEGIN,  16'd0,    8'h00);
        // second push_begin while a push is open
        send_request(REQ_PUSH_BEGIN, 16'd3,    8'h00);
        send_request(REQ_PUSH_BEGIN, 16'd9,    8'h00);
        send_request(REQ_PUSH_DATA,  16'd0,    8'h00);
        send_request(REQ_PUSH_DATA,  16'hFFFF, 8'hFF);
        send_request(REQ_PUSH_DATA,  16'd0,    8'hA5);
        // reader too small: third byte is skipped
        send_request(REQ_POP_BEGIN,  16'd3,    8'h00);
        send_request(REQ_POP_BEGIN,  16'd4,    8'h00);
        send_request(REQ_POP_DATA,   16'd0,    8'h00);
        send_request(REQ_POP_DATA,   16'd0,    8'h00);
        send_request(REQ_POP_DATA,   16'd0,    8'h00);
        send_request(REQ_PUSH_BEGIN, 16'd1,    8'h00);
        send_request(REQ_PUSH_DATA,  16'd0,    8'h3C);
        send_request(REQ_POP_BEGIN,  16'hFFFF, 8'h00);
        send_request(REQ_POP_DATA,   16'd0,    8'h00);

        // smallest ring: length clamp, full rejection and wrap
        drain();
        write_size(3);
        send_request(REQ_PUSH_BEGIN, 16'hFFFF, 8'h00);
        send_request(REQ_PUSH_BEGIN, 16'd0,    8'h00);
        send_request(REQ_PUSH_DATA,  16'd0,    8'h5A);
        send_request(REQ_PUSH_BEGIN, 16'd0,    8'h00);
        send_request(REQ_POP_BEGIN,  16'd2,    8'h00);
        send_request(REQ_POP_DATA,   16'd0,    8'h00);
        send_request(REQ_PUSH_BEGIN, 16'd1,    8'h00);

        run_phase(1024, 250, 50, 20, 1'b0);
        run_phase(3,    120, 50, 10, 1'b0);
        run_phase(10,   150, 45,  0, 1'b0);
        run_phase(37,   200, 30, 25, 1'b0);
        run_phase(300,  250, 55, 12, 1'b0);
        run_phase(1023, 200, 40, 18, 1'b0);
        run_phase(6,    130, 50,  8, 1'b0);
        run_phase(1024, 250, 35,  0, 1'b1);

        drain();
        repeat (20) @(negedge clk);

        $display("%0d requests over %0d ring sizes, %0d results compared, %0d mismatches",
                 requests_out, sizes_run, results_checked, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS length_prefixed_message_fifo");
        else
            $display("FAIL length_prefixed_message_fifo");
        $finish;
    end

endmodule
